[rtl/metropolis_transition_test_assert.svh]
// Assertion macros for the transition test block.
`ifndef METROPOLIS_TRANSITION_TEST_ASSERT_SVH
`define METROPOLIS_TRANSITION_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define MTT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
`define MTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define MTT_ASSERT(lbl, clk, rst_n, prop)
`define MTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mtt_pkg.sv]
// Shared types, constants and root table of the transition test block.
package mtt_pkg;

	localparam logic [31:0] LN2_Q32       = 32'hB172_17F8;
	localparam logic [31:0] ONE_Q16       = 32'h0001_0000;
	localparam logic [31:0] ONE_Q31       = 32'h8000_0000;
	localparam logic [31:0] MIN_TEMP_RST  = 32'h0001_0000;
	localparam logic [15:0] HEAT_RATE_RST = 16'h1000;

	localparam int DIV_REM_W = 32;
	localparam int DIV_DVD_W = 36;
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS_COST = 6'd36;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS_TEMP = 6'd32;

	typedef enum logic [1:0] {
		CMD_TEST    = 2'd0,
		CMD_RECORD  = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_COST_LIMIT = 2'd0,
		REG_MIN_TEMP   = 2'd1,
		REG_HEAT_RATE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DIV_REM_W-1:0] rem;
		logic [DIV_DVD_W-1:0] dividend;
		logic [DIV_REM_W-1:0] divisor;
		logic [DIV_CNT_W-1:0] steps;
	} div_load_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x = x_in;
		res = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q1.31, by repeated square roots starting at 2.0
	function automatic logic [31:0] pow2_root(input int k);
		logic [63:0] s;
		s = 64'h0000_0001_0000_0000;
		for (int i = 0; i < 16; i++) begin
			if (i < k) begin
				s = isqrt64(s << 31);
			end
		end
		return s[31:0];
	endfunction

	localparam logic [31:0] ROOT_TAB [16] = '{
		pow2_root(1),  pow2_root(2),  pow2_root(3),  pow2_root(4),
		pow2_root(5),  pow2_root(6),  pow2_root(7),  pow2_root(8),
		pow2_root(9),  pow2_root(10), pow2_root(11), pow2_root(12),
		pow2_root(13), pow2_root(14), pow2_root(15), pow2_root(16)
	};

endpackage

[rtl/mtt_divider.sv]
// Shift-subtract divider, one quotient bit per cycle.
module mtt_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  mtt_pkg::div_load_t               load,
	output logic                             done,
	output logic [mtt_pkg::DIV_DVD_W-1:0]    quotient
);

	logic [mtt_pkg::DIV_REM_W-1:0] rem_q;
	logic [mtt_pkg::DIV_DVD_W-1:0] dvd_q;
	logic [mtt_pkg::DIV_REM_W-1:0] dvs_q;
	logic [mtt_pkg::DIV_DVD_W-1:0] quo_q;
	logic [mtt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [mtt_pkg::DIV_REM_W:0] sh;
	logic [mtt_pkg::DIV_REM_W:0] diff;
	logic                        fits;

	assign sh   = {rem_q, dvd_q[mtt_pkg::DIV_DVD_W-1]};
	assign diff = sh - {1'b0, dvs_q};
	assign fits = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= load.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= load.rem;
			dvd_q <= load.dividend;
			dvs_q <= load.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[mtt_pkg::DIV_REM_W-1:0] : sh[mtt_pkg::DIV_REM_W-1:0];
			dvd_q <= {dvd_q[mtt_pkg::DIV_DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[mtt_pkg::DIV_DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/metropolis_transition_test.sv]
// Transition test with temperature tuning and cost bounds: top level.
// Record, restart, unused, over-limit and downhill items go straight to the output stage;
// rejected uphill items take two multiplies and 12 root multiplies, and accepted uphill
// items use the shared divider (36 + 32 steps) and 16 root multiplies.
// One item at a time: s_axis_tready rises with m_axis_tvalid.
// arst_n clears control state, registers to their reset values and temperature to 1.0.
`include "metropolis_transition_test_assert.svh"
module metropolis_transition_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // from_cost[31:0], to_cost[63:32]
	input  logic [2:0]  s_axis_tuser,   // command[1:0], goal_present[2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // accepted[0], over_limit[1], temperature_now[33:2]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LN2,
		ST_TEST,
		ST_DIV_E,
		ST_POW,
		ST_DIV_T_GO,
		ST_DIV_T,
		ST_HEAT_MUL,
		ST_HEAT,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [30:0] limit_q;
	logic [31:0] min_temp_q;
	logic [15:0] heat_rate_q;

	logic [31:0]        temp_q;
	logic signed [31:0] low_q;
	logic signed [31:0] high_q;
	logic [31:0]        d_q;
	logic [63:0]        prod_q;
	logic [31:0]        m_q;
	logic [15:0]        frac_q;
	logic [3:0]         k_q;
	logic [3:0]         last_k_q;
	logic               cool_q;
	logic               ip_big_q;
	logic [4:0]         ip_q;
	logic               acc_q;
	logic               over_q;
	logic               m_valid_q;
	logic [39:0]        m_data_q;
	logic               div_start_q;
	mtt_pkg::div_load_t div_load_q;

	logic                            div_done;
	logic [mtt_pkg::DIV_DVD_W-1:0]   div_quo;

	logic               cfg_wr;
	mtt_pkg::reg_idx_t  reg_idx;
	logic               in_acc;
	mtt_pkg::cmd_t      cmd;
	logic               goal;
	logic signed [31:0] from_c;
	logic signed [31:0] to_c;
	logic               over_c;
	logic               downhill_c;
	logic [32:0]        diff_c;
	logic signed [32:0] r_c;
	logic [31:0]        range_c;
	logic [35:0]        d10_c;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [31:0]        cool_q_c;
	logic [31:0]        cool_t_c;
	logic [47:0]        heat_p_c;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = mtt_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= '0;
			min_temp_q  <= mtt_pkg::MIN_TEMP_RST;
			heat_rate_q <= mtt_pkg::HEAT_RATE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				mtt_pkg::REG_COST_LIMIT: limit_q     <= pwdata[30:0];
				mtt_pkg::REG_MIN_TEMP:   min_temp_q  <= pwdata;
				mtt_pkg::REG_HEAT_RATE:  heat_rate_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mtt_pkg::REG_COST_LIMIT: prdata = {1'b0, limit_q};
			mtt_pkg::REG_MIN_TEMP:   prdata = min_temp_q;
			mtt_pkg::REG_HEAT_RATE:  prdata = {16'b0, heat_rate_q};
			default:                 prdata = '0;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cmd           = mtt_pkg::cmd_t'(s_axis_tuser[1:0]);
	assign goal          = s_axis_tuser[2];
	assign from_c        = $signed(s_axis_tdata[31:0]);
	assign to_c          = $signed(s_axis_tdata[63:32]);
	assign over_c        = (limit_q != '0) && (to_c > $signed({1'b0, limit_q}));
	assign downhill_c    = to_c <= from_c;
	assign diff_c        = {to_c[31], to_c} - {from_c[31], from_c};

	assign r_c     = $signed({high_q[31], high_q} - {low_q[31], low_q});
	assign range_c = (r_c < 33'sd65536) ? mtt_pkg::ONE_Q16 : r_c[31:0];
	assign d10_c   = ({4'b0, d_q} << 3) + ({4'b0, d_q} << 1);

	always_comb begin
		case (state_q)
			ST_POW: begin
				mul_a = m_q;
				mul_b = mtt_pkg::ROOT_TAB[k_q];
			end
			ST_HEAT_MUL: begin
				mul_a = temp_q;
				mul_b = m_q;
			end
			default: begin
				mul_a = temp_q;
				mul_b = mtt_pkg::LN2_Q32;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign cool_q_c = ip_big_q ? '0 : (div_quo[31:0] >> ip_q);
	assign cool_t_c = (cool_q_c < min_temp_q) ? min_temp_q : cool_q_c;
	assign heat_p_c = {15'b0, prod_q[63:31]} << heat_rate_q[15:12];

	mtt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.load     (div_load_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			temp_q      <= mtt_pkg::MIN_TEMP_RST;
			low_q       <= '0;
			high_q      <= '0;
			m_valid_q   <= 1'b0;
			div_start_q <= 1'b0;
			acc_q       <= 1'b0;
			over_q      <= 1'b0;
			cool_q      <= 1'b0;
			k_q         <= '0;
			last_k_q    <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (m_axis_tvalid && m_axis_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						acc_q   <= 1'b0;
						over_q  <= 1'b0;
						state_q <= ST_DONE;
						case (cmd)
							mtt_pkg::CMD_TEST: begin
								if (over_c) begin
									over_q <= 1'b1;
								end else if (downhill_c) begin
									acc_q <= 1'b1;
								end else begin
									d_q     <= diff_c[31:0];
									state_q <= ST_LN2;
								end
							end
							mtt_pkg::CMD_RECORD: begin
								if (from_c > high_q) begin
									high_q <= from_c;
								end
								if (from_c < low_q) begin
									low_q <= from_c;
								end
							end
							mtt_pkg::CMD_RESTART: begin
								high_q <= (goal && to_c > from_c) ? to_c : from_c;
								low_q  <= (goal && to_c < from_c) ? to_c : from_c;
								temp_q <= min_temp_q;
							end
							default: ;
						endcase
					end
				end
				ST_LN2: begin
					prod_q  <= mul_p;
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if ({d_q, 32'b0} < prod_q) begin
						div_load_q.rem      <= {16'b0, d10_c[35:20]};
						div_load_q.dividend <= {d10_c[19:0], 16'b0};
						div_load_q.divisor  <= range_c;
						div_load_q.steps    <= mtt_pkg::DIV_STEPS_COST;
						div_start_q         <= 1'b1;
						state_q             <= ST_DIV_E;
					end else begin
						m_q      <= mtt_pkg::ONE_Q31;
						frac_q   <= {heat_rate_q[11:0], 4'b0};
						k_q      <= '0;
						last_k_q <= 4'd11;
						cool_q   <= 1'b0;
						state_q  <= ST_POW;
					end
				end
				ST_DIV_E: begin
					if (div_done) begin
						ip_big_q <= |div_quo[35:21];
						ip_q     <= div_quo[20:16];
						frac_q   <= div_quo[15:0];
						m_q      <= mtt_pkg::ONE_Q31;
						k_q      <= '0;
						last_k_q <= 4'd15;
						cool_q   <= 1'b1;
						state_q  <= ST_POW;
					end
				end
				ST_POW: begin
					if (frac_q[15]) begin
						m_q <= mul_p[62:31];
					end
					frac_q <= {frac_q[14:0], 1'b0};
					k_q    <= k_q + 1'b1;
					if (k_q == last_k_q) begin
						state_q <= cool_q ? ST_DIV_T_GO : ST_HEAT_MUL;
					end
				end
				ST_DIV_T_GO: begin
					div_load_q.rem      <= {1'b0, temp_q[31:1]};
					div_load_q.dividend <= {temp_q[0], 35'b0};
					div_load_q.divisor  <= m_q;
					div_load_q.steps    <= mtt_pkg::DIV_STEPS_TEMP;
					div_start_q         <= 1'b1;
					state_q             <= ST_DIV_T;
				end
				ST_DIV_T: begin
					if (div_done) begin
						temp_q  <= cool_t_c;
						acc_q   <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_HEAT_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_HEAT;
				end
				ST_HEAT: begin
					temp_q  <= (|heat_p_c[47:32]) ? 32'hFFFF_FFFF : heat_p_c[31:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {6'b0, temp_q, over_q, acc_q};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`MTT_ASSERT(a_bounds_order, clk, arst_n, low_q <= high_q)
	`MTT_ASSERT_NEXT(a_one_item, clk, arst_n, in_acc, !s_axis_tready)
	`MTT_ASSERT_NEXT(a_cool_floor, clk, arst_n, state_q == ST_DIV_T && div_done,
		temp_q >= min_temp_q)
	`MTT_ASSERT(a_acc_excl, clk, arst_n, !(m_valid_q && m_data_q[0] && m_data_q[1]))

endmodule
